>>> rtl/log_record_deframer_crc_check_top_assert.svh
// ----------------------------------------------------------------------------
// log record deframer assertion macros
// concurrent assertion helpers clocked on aclk
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_CRC_CHECK_TOP_ASSERT_SVH
`define LOG_RECORD_DEFRAMER_CRC_CHECK_TOP_ASSERT_SVH

// checked only outside reset
`define LRDCC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define LRDCC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/lrdcc_pkg.sv
// ----------------------------------------------------------------------------
// lrdcc_pkg
// shared types, codes and the crc-32 byte step of the log record deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lrdcc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] MIN_LEN  = 32'd9;
    localparam logic [7:0]  TAG_WRITE_CHAR  = 8'h57;
    localparam logic [7:0]  TAG_COMMIT_CHAR = 8'h4B;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // record tags
    localparam logic [1:0] TAG_WRITE  = 2'd0;
    localparam logic [1:0] TAG_COMMIT = 2'd1;
    localparam logic [1:0] TAG_OTHER  = 2'd2;

    // stop causes
    localparam logic [1:0] CAUSE_SHORT = 2'd0;
    localparam logic [1:0] CAUSE_CRC   = 2'd1;
    localparam logic [1:0] CAUSE_MID   = 2'd2;
    localparam logic [1:0] CAUSE_CLEAN = 2'd3;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // what one input word leaves for the back end
    typedef struct packed {
        logic        has_data;
        logic [7:0]  data_byte;
        logic        has_end;
        logic        verified;
        logic [1:0]  tag;
        logic [63:0] txn;
        logic [1:0]  cause;
    } event_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lrdcc_front.sv
// ----------------------------------------------------------------------------
// lrdcc_front
// header parsing, crc-32 over the payload and record classification
// ----------------------------------------------------------------------------
`default_nettype none

module lrdcc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              op,
    input  wire logic [7:0]        log_byte,
    output lrdcc_pkg::event_t      ev,
    output logic                   ev_push
);

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_CRC  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] stored_reg, stored_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] pay_cnt_reg, pay_cnt_next;
    logic [1:0]  tag_reg, tag_next;
    logic [63:0] txn_reg, txn_next;

    logic [31:0] crc_step;
    logic [31:0] pay_cnt_inc;
    logic [2:0]  txn_idx;

    assign crc_step    = lrdcc_pkg::crc32_byte(crc_reg, log_byte);
    assign pay_cnt_inc = pay_cnt_reg + 32'd1;
    assign txn_idx     = pay_cnt_reg[2:0] - 3'd1;

    always_comb begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        len_next     = len_reg;
        stored_next  = stored_reg;
        crc_next     = crc_reg;
        pay_cnt_next = pay_cnt_reg;
        tag_next     = tag_reg;
        txn_next     = txn_reg;
        ev           = '0;
        ev_push      = 1'b0;

        if (accept && phase_reg != PH_STOP) begin
            if (op == lrdcc_pkg::OP_EOL) begin
                ev.has_end = 1'b1;
                ev.cause   = (phase_reg == PH_LEN && hdr_cnt_reg == 2'd0)
                           ? lrdcc_pkg::CAUSE_CLEAN : lrdcc_pkg::CAUSE_MID;
                ev_push    = 1'b1;
                phase_next = PH_STOP;
            end else begin
                unique case (phase_reg)
                    PH_LEN: begin
                        len_next[{hdr_cnt_reg, 3'b000} +: 8] = log_byte;
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                        if (hdr_cnt_reg == 2'd3) begin
                            stored_next = '0;
                            phase_next  = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        stored_next[{hdr_cnt_reg, 3'b000} +: 8] = log_byte;
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                        if (hdr_cnt_reg == 2'd3) begin
                            if (len_reg < lrdcc_pkg::MIN_LEN) begin
                                ev.has_end = 1'b1;
                                ev.cause   = lrdcc_pkg::CAUSE_SHORT;
                                ev_push    = 1'b1;
                                phase_next = PH_STOP;
                            end else begin
                                phase_next   = PH_PAY;
                                pay_cnt_next = '0;
                                crc_next     = lrdcc_pkg::CRC_INIT;
                                tag_next     = lrdcc_pkg::TAG_WRITE;
                                txn_next     = '0;
                            end
                        end
                    end
                    PH_PAY: begin
                        crc_next     = crc_step;
                        pay_cnt_next = pay_cnt_inc;
                        if (pay_cnt_reg == 32'd0) begin
                            if (log_byte == lrdcc_pkg::TAG_WRITE_CHAR) begin
                                tag_next = lrdcc_pkg::TAG_WRITE;
                            end else if (log_byte == lrdcc_pkg::TAG_COMMIT_CHAR) begin
                                tag_next = lrdcc_pkg::TAG_COMMIT;
                            end else begin
                                tag_next = lrdcc_pkg::TAG_OTHER;
                            end
                        end else if (pay_cnt_reg <= 32'd8) begin
                            txn_next[{txn_idx, 3'b000} +: 8] = log_byte;
                        end else begin
                            ev.has_data  = 1'b1;
                            ev.data_byte = log_byte;
                            ev_push      = 1'b1;
                        end
                        if (pay_cnt_inc == len_reg) begin
                            ev.has_end = 1'b1;
                            ev_push    = 1'b1;
                            if (~crc_step == stored_reg) begin
                                ev.verified  = 1'b1;
                                ev.tag       = tag_next;
                                ev.txn       = txn_next;
                                phase_next   = PH_LEN;
                                hdr_cnt_next = '0;
                                len_next     = '0;
                                stored_next  = '0;
                                pay_cnt_next = '0;
                            end else begin
                                ev.cause   = lrdcc_pkg::CAUSE_CRC;
                                phase_next = PH_STOP;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEN;
            hdr_cnt_reg <= '0;
            len_reg     <= '0;
            stored_reg  <= '0;
            crc_reg     <= lrdcc_pkg::CRC_INIT;
            pay_cnt_reg <= '0;
            tag_reg     <= '0;
            txn_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            len_reg     <= len_next;
            stored_reg  <= stored_next;
            crc_reg     <= crc_next;
            pay_cnt_reg <= pay_cnt_next;
            tag_reg     <= tag_next;
            txn_reg     <= txn_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lrdcc_queue.sv
// ----------------------------------------------------------------------------
// lrdcc_queue
// short event fifo between the parser and the result sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "log_record_deframer_crc_check_top_assert.svh"

module lrdcc_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire lrdcc_pkg::event_t push_ev,
    input  wire logic              pop,
    output lrdcc_pkg::event_t      head_ev,
    output logic                   not_empty,
    output logic                   not_full
);

    lrdcc_pkg::event_t mem_reg [lrdcc_pkg::QUEUE_DEPTH];

    logic [lrdcc_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [lrdcc_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic [lrdcc_pkg::QUEUE_CW-1:0] full_level;
    logic [lrdcc_pkg::QUEUE_AW-1:0] ptr_gap;

    assign full_level = lrdcc_pkg::QUEUE_CW'(lrdcc_pkg::QUEUE_DEPTH);
    assign ptr_gap    = wr_ptr_reg - rd_ptr_reg;
    assign not_empty  = (count_reg != '0);
    assign not_full   = (count_reg != full_level);
    assign head_ev    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `LRDCC_ASSERT(a_count_bound, count_reg <= full_level, "event queue count above depth")
    `LRDCC_ASSERT(a_no_push_full, push |-> not_full, "event pushed into full queue")
    `LRDCC_ASSERT(a_no_pop_empty, pop |-> not_empty, "event popped from empty queue")
    `LRDCC_ASSERT(a_count_up, (push && !pop) |=> count_reg > $past(count_reg), "count missed a push")
    `LRDCC_ASSERT(a_ptr_gap, ptr_gap == count_reg[lrdcc_pkg::QUEUE_AW-1:0], "pointer gap off")

endmodule

`default_nettype wire

>>> rtl/lrdcc_back.sv
// ----------------------------------------------------------------------------
// lrdcc_back
// turns queued events into one or two result words on the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lrdcc_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lrdcc_pkg::event_t head_ev,
    input  wire logic              head_valid,
    output logic                   pop,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic [1:0]             m_out_kind,
    output logic [7:0]             m_data_byte,
    output logic [1:0]             m_record_tag,
    output logic [63:0]            m_txn_id,
    output logic [1:0]             m_stop_cause
);

    logic        valid_reg;
    logic        data_done_reg, data_done_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [1:0]  tag_reg, tag_next;
    logic [63:0] txn_reg, txn_next;
    logic [1:0]  cause_reg, cause_next;
    logic        load;
    logic        emit_data;

    assign load      = head_valid && (!valid_reg || m_ready);
    // data word goes first when the event carries one not yet sent
    assign emit_data = head_ev.has_data && !data_done_reg;
    assign pop       = load && !(emit_data && head_ev.has_end);

    always_comb begin
        data_done_next = data_done_reg;
        kind_next      = lrdcc_pkg::KIND_DATA;
        data_next      = '0;
        tag_next       = '0;
        txn_next       = '0;
        cause_next     = '0;
        if (load) begin
            data_done_next = !pop;
        end
        if (emit_data) begin
            data_next = head_ev.data_byte;
        end else if (head_ev.verified) begin
            kind_next = lrdcc_pkg::KIND_END;
            tag_next  = head_ev.tag;
            txn_next  = head_ev.txn;
        end else begin
            kind_next  = lrdcc_pkg::KIND_STOP;
            cause_next = head_ev.cause;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            data_done_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            data_done_reg <= data_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            tag_reg   <= tag_next;
            txn_reg   <= txn_next;
            cause_reg <= cause_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_data_byte  = data_reg;
    assign m_record_tag = tag_reg;
    assign m_txn_id     = txn_reg;
    assign m_stop_cause = cause_reg;

endmodule

`default_nettype wire

>>> rtl/log_record_deframer_crc_check_top.sv
// a word that yields a result passes through the event queue into the output register
// throughput: one log byte per cycle while s_ready is high; crc-32 step is combinational
// a last data byte yields two results; the second goes out after the data word
// the four-entry event queue absorbs the second result and output stalls
// reset: synchronous active-low aresetn clears parser state, queue and output valid
// ----------------------------------------------------------------------------
// log_record_deframer_crc_check_top
// write-ahead log record deframer with crc-32 check
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_deframer_crc_check_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_log_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_data_byte,
    output logic [1:0]       m_record_tag,
    output logic [63:0]      m_txn_id,
    output logic [1:0]       m_stop_cause
);

    lrdcc_pkg::event_t push_ev;
    lrdcc_pkg::event_t head_ev;
    logic              push;
    logic              pop;
    logic              not_empty;
    logic              not_full;
    logic              accept;

    assign s_ready = not_full;
    assign accept  = s_valid && not_full;

    lrdcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .op       (s_op),
        .log_byte (s_log_byte),
        .ev       (push_ev),
        .ev_push  (push)
    );

    lrdcc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_ev   (push_ev),
        .pop       (pop),
        .head_ev   (head_ev),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    lrdcc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_ev      (head_ev),
        .head_valid   (not_empty),
        .pop          (pop),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_kind   (m_out_kind),
        .m_data_byte  (m_data_byte),
        .m_record_tag (m_record_tag),
        .m_txn_id     (m_txn_id),
        .m_stop_cause (m_stop_cause)
    );

endmodule

`default_nettype wire
